FILE: rtl/plane_point_side_and_distance_macros.svh
// ----------------------------------------------------------------------------
// plane_point_side_and_distance_macros
// assertion macros shared by the plane side and distance block
// ----------------------------------------------------------------------------
`ifndef PLANE_POINT_SIDE_AND_DISTANCE_MACROS_SVH
`define PLANE_POINT_SIDE_AND_DISTANCE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PPSD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppsd assertion failed");
`define PPSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppsd assertion failed");
`else
`define PPSD_ASSERT_IMPLY(lbl, ante, cons)
`define PPSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/ppsd_pkg.sv
// ----------------------------------------------------------------------------
// ppsd_pkg
// widths, codes and payload types of the plane side and distance block
// ----------------------------------------------------------------------------
package ppsd_pkg;

	localparam int CW = 24;
	localparam int FRAC = 12;
	localparam int BW = CW + 1;
	localparam int HW = CW + 3;
	localparam int PW = HW + BW;
	localparam int MW = PW - 1;
	localparam int QW = CW - 1;
	localparam int CFG_IDX_W = 3;

	localparam logic [CW-1:0] NORMAL_RESET = {{(CW-1){1'b0}}, 1'b1} << FRAC;
	localparam logic [QW-1:0] DIST_MAX = {QW{1'b1}};

	localparam logic [1:0] SIDE_ON = 2'd0;
	localparam logic [1:0] SIDE_OUT = 2'd1;
	localparam logic [1:0] SIDE_IN = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_ANCHOR_X = 3'd3,
		REG_ANCHOR_Y = 3'd4,
		REG_ANCHOR_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic first_of_set;
	} point_item_t;

	typedef struct packed {
		logic [1:0] side;
		logic [QW-1:0] distance;
		logic both_sides;
	} result_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

FILE: rtl/ppsd_mac.sv
// ----------------------------------------------------------------------------
// ppsd_mac
// bit-serial three-lane multiply-accumulate, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ppsd_mac (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [ppsd_pkg::CW-1:0] a_x,
	input logic signed [ppsd_pkg::CW-1:0] a_y,
	input logic signed [ppsd_pkg::CW-1:0] a_z,
	input logic signed [ppsd_pkg::BW-1:0] b_x,
	input logic signed [ppsd_pkg::BW-1:0] b_y,
	input logic signed [ppsd_pkg::BW-1:0] b_z,
	output ppsd_pkg::unit_status_t status,
	output logic signed [ppsd_pkg::PW-1:0] result
);

	localparam int CW = ppsd_pkg::CW;
	localparam int BW = ppsd_pkg::BW;
	localparam int HW = ppsd_pkg::HW;
	localparam int CNT_W = $clog2(BW);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BW-1:0] bx_q, by_q, bz_q;
	logic signed [HW-1:0] hi_q;
	logic [BW-1:0] lo_q;

	logic signed [HW-1:0] ext_x, ext_y, ext_z, pp, sum;
	logic last;

	always_comb begin
		ext_x = {{(HW-CW){a_x[CW-1]}}, a_x};
		ext_y = {{(HW-CW){a_y[CW-1]}}, a_y};
		ext_z = {{(HW-CW){a_z[CW-1]}}, a_z};
		pp = (bx_q[0] ? ext_x : '0) + (by_q[0] ? ext_y : '0) + (bz_q[0] ? ext_z : '0);
		last = (cnt_q == CNT_W'(BW - 1));
		// the top multiplier bit carries negative weight
		sum = last ? (hi_q - pp) : (hi_q + pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bx_q <= b_x;
			by_q <= b_y;
			bz_q <= b_z;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			bx_q <= bx_q >> 1;
			by_q <= by_q >> 1;
			bz_q <= bz_q >> 1;
			hi_q <= {sum[HW-1], sum[HW-1:1]};
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign result = {hi_q, lo_q};

endmodule

FILE: rtl/ppsd_isqrt.sv
// ----------------------------------------------------------------------------
// ppsd_isqrt
// digit-by-digit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module ppsd_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2*ppsd_pkg::CW-1:0] radicand,
	output ppsd_pkg::unit_status_t status,
	output logic [ppsd_pkg::CW-1:0] root
);

	localparam int CW = ppsd_pkg::CW;
	localparam int XW = 2 * CW;
	localparam int RW = CW + 2;
	localparam int CNT_W = $clog2(CW);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] root_q;

	logic [RW-1:0] rem_sh, trial;
	logic ge, last;

	always_comb begin
		rem_sh = {rem_q[RW-3:0], x_q[XW-1 -: 2]};
		trial = {root_q, 2'b01};
		ge = (rem_sh >= trial);
		last = (cnt_q == CNT_W'(CW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[CW-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/ppsd_div.sv
// ----------------------------------------------------------------------------
// ppsd_div
// restoring serial divider with saturation, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppsd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ppsd_pkg::MW-1:0] dividend,
	input logic [ppsd_pkg::CW-1:0] divisor,
	output ppsd_pkg::unit_status_t status,
	output logic [ppsd_pkg::QW-1:0] quotient
);

	localparam int CW = ppsd_pkg::CW;
	localparam int MW = ppsd_pkg::MW;
	localparam int QW = ppsd_pkg::QW;
	localparam int HIW = MW - QW;
	localparam int CNT_W = $clog2(QW);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0] rem_q, div_q;
	logic [QW-1:0] lo_q, quot_q;

	logic [HIW-1:0] head;
	logic sat;
	logic [CW:0] trial, diff;
	logic ge, last;

	always_comb begin
		head = dividend[MW-1:QW];
		// quotient would not fit, or zero divisor
		sat = (divisor == '0) || (head >= HIW'(divisor));
		trial = {rem_q, lo_q[QW-1]};
		diff = trial - {1'b0, div_q};
		ge = (trial >= {1'b0, div_q});
		last = (cnt_q == CNT_W'(QW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= !sat;
				done_q <= sat;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= head[CW-1:0];
			lo_q <= dividend[QW-1:0];
			div_q <= divisor;
			quot_q <= sat ? ppsd_pkg::DIST_MAX : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			lo_q <= lo_q << 1;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient = quot_q;

endmodule

FILE: rtl/plane_point_side_and_distance.sv
// ----------------------------------------------------------------------------
// plane_point_side_and_distance
// side of a point against a configured plane and its distance to the plane
// ----------------------------------------------------------------------------
// Points come in on point_valid / point_data and are taken while point_stall
// is low; one result leaves on result_valid / result_data per point, held
// until result_stall is low. The plane is loaded through cfg_wr_en,
// cfg_index and cfg_data: indexes 0 to 2 are the normal, 3 to 5 the anchor.
// A point runs a bit-serial dot product n.(p - q), a sign step and a serial
// divide by the normal length; no new point is taken until it is done. When
// the distance clips or the normal is zero the divide is skipped. The normal
// length comes from a separate serial sum-of-squares and square-root unit
// that runs after reset and after every write to a normal register; a point
// arriving before the length is ready waits before its divide. A stalled
// receiver holds the result register; a finished point waits behind it and
// the next request is held off until that point has moved into the result
// register. Reset restores the default plane (normal along z, anchor at the
// origin) and clears the inside and outside flags.
// ----------------------------------------------------------------------------
`include "plane_point_side_and_distance_macros.svh"

module plane_point_side_and_distance (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input ppsd_pkg::point_item_t point_data,
	output logic result_valid,
	input logic result_stall,
	output ppsd_pkg::result_item_t result_data,
	input logic cfg_wr_en,
	input logic [ppsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppsd_pkg::CW-1:0] cfg_data
);

	localparam int CW = ppsd_pkg::CW;
	localparam int BW = ppsd_pkg::BW;
	localparam int PW = ppsd_pkg::PW;
	localparam int MW = ppsd_pkg::MW;
	localparam int QW = ppsd_pkg::QW;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MAC  = 6'b000010,
		ST_SIGN = 6'b000100,
		ST_WAIT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		LEN_NORM = 3'b001,
		LEN_ROOT = 3'b010,
		LEN_DONE = 3'b100
	} len_phase_t;

	state_t state_q;
	len_phase_t len_phase_q;
	logic len_kick_q;

	logic signed [CW-1:0] normal_x_q, normal_y_q, normal_z_q;
	logic signed [CW-1:0] anchor_x_q, anchor_y_q, anchor_z_q;

	logic seen_in_q, seen_out_q;
	logic first_q;
	logic [1:0] side_q;
	logic both_q;
	logic [MW-1:0] mag_q;

	logic result_valid_q;
	ppsd_pkg::result_item_t result_q;

	logic accept, normal_wr, out_free, div_start;
	logic signed [BW-1:0] d_x, d_y, d_z;
	logic signed [BW-1:0] nb_x, nb_y, nb_z;
	logic signed [PW-1:0] dot_result, len_result;
	logic [PW-1:0] dot_abs;
	logic dot_zero, dot_neg;
	logic seen_in_next, seen_out_next;
	logic [CW-1:0] len_root;
	logic [QW-1:0] quot;

	ppsd_pkg::unit_status_t dot_st, len_mac_st, root_st, div_st;

	always_comb begin
		accept = point_valid && !point_stall;
		normal_wr = cfg_wr_en && (cfg_index == ppsd_pkg::REG_NORMAL_X
			|| cfg_index == ppsd_pkg::REG_NORMAL_Y || cfg_index == ppsd_pkg::REG_NORMAL_Z);
		out_free = !result_valid_q || !result_stall;
		div_start = (state_q == ST_WAIT) && (len_phase_q == LEN_DONE);

		d_x = {point_data.point_x[CW-1], point_data.point_x} - {anchor_x_q[CW-1], anchor_x_q};
		d_y = {point_data.point_y[CW-1], point_data.point_y} - {anchor_y_q[CW-1], anchor_y_q};
		d_z = {point_data.point_z[CW-1], point_data.point_z} - {anchor_z_q[CW-1], anchor_z_q};
		nb_x = {normal_x_q[CW-1], normal_x_q};
		nb_y = {normal_y_q[CW-1], normal_y_q};
		nb_z = {normal_z_q[CW-1], normal_z_q};

		dot_zero = (dot_result == '0);
		dot_neg = dot_result[PW-1];
		dot_abs = dot_neg ? (~dot_result + PW'(1)) : dot_result;
		seen_in_next = (seen_in_q && !first_q) || dot_neg;
		seen_out_next = (seen_out_q && !first_q) || (!dot_neg && !dot_zero);
	end

	assign point_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= '0;
			normal_z_q <= ppsd_pkg::NORMAL_RESET;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			anchor_z_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ppsd_pkg::REG_NORMAL_X: normal_x_q <= cfg_data;
				ppsd_pkg::REG_NORMAL_Y: normal_y_q <= cfg_data;
				ppsd_pkg::REG_NORMAL_Z: normal_z_q <= cfg_data;
				ppsd_pkg::REG_ANCHOR_X: anchor_x_q <= cfg_data;
				ppsd_pkg::REG_ANCHOR_Y: anchor_y_q <= cfg_data;
				ppsd_pkg::REG_ANCHOR_Z: anchor_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// normal length: sum of squares, then square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_kick_q <= 1'b1;
			len_phase_q <= LEN_NORM;
		end else begin
			len_kick_q <= normal_wr;
			if (normal_wr || len_kick_q) begin
				len_phase_q <= LEN_NORM;
			end else if (len_phase_q == LEN_NORM && len_mac_st.done) begin
				len_phase_q <= LEN_ROOT;
			end else if (len_phase_q == LEN_ROOT && root_st.done) begin
				len_phase_q <= LEN_DONE;
			end
		end
	end

	ppsd_mac u_len_mac (
		.clk(clk),
		.arst_n(arst_n),
		.start(len_kick_q),
		.a_x(normal_x_q),
		.a_y(normal_y_q),
		.a_z(normal_z_q),
		.b_x(nb_x),
		.b_y(nb_y),
		.b_z(nb_z),
		.status(len_mac_st),
		.result(len_result)
	);

	ppsd_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(len_phase_q == LEN_NORM && len_mac_st.done && !len_kick_q && !normal_wr),
		.radicand(len_result[2*CW-1:0]),
		.status(root_st),
		.root(len_root)
	);

	ppsd_mac u_dot_mac (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.a_x(normal_x_q),
		.a_y(normal_y_q),
		.a_z(normal_z_q),
		.b_x(d_x),
		.b_y(d_y),
		.b_z(d_z),
		.status(dot_st),
		.result(dot_result)
	);

	ppsd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(mag_q),
		.divisor(len_root),
		.status(div_st),
		.quotient(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_in_q <= 1'b0;
			seen_out_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (dot_st.done) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					seen_in_q <= seen_in_next;
					seen_out_q <= seen_out_next;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= point_data.first_of_set;
		end
		if (state_q == ST_SIGN) begin
			mag_q <= dot_abs[MW-1:0];
			both_q <= seen_in_next && seen_out_next;
			if (dot_zero) begin
				side_q <= ppsd_pkg::SIDE_ON;
			end else if (dot_neg) begin
				side_q <= ppsd_pkg::SIDE_IN;
			end else begin
				side_q <= ppsd_pkg::SIDE_OUT;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			result_q.side <= side_q;
			result_q.distance <= quot;
			result_q.both_sides <= both_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

	`PPSD_ASSERT_IMPLY(a_on_plane_dist, result_valid && result_data.side == ppsd_pkg::SIDE_ON, result_data.distance == '0 || result_data.distance == ppsd_pkg::DIST_MAX)
	`PPSD_ASSERT_IMPLY(a_accept_units_free, point_valid && !point_stall, !dot_st.busy && !div_st.busy)
	`PPSD_ASSERT_IMPLY(a_dot_done_in_mac, dot_st.done, state_q == ST_MAC)
	`PPSD_ASSERT_IMPLY(a_len_done_quiet, len_phase_q == LEN_DONE, !len_mac_st.busy && !root_st.busy)
	`PPSD_ASSERT_NEXT(a_fin_loads_out, state_q == ST_FIN && out_free, result_valid && state_q == ST_IDLE)

endmodule
